// ===== rtl/core/bpi_pkg.sv =====
// breakpoint interpolator package: widths, codes and pipeline record types
// no dependencies
`timescale 1ns / 1ps

package bpi_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxWidth   = 4;
  localparam int unsigned SizeWidth  = 5;
  // quotient never exceeds the slope magnitude, so it fits in value width plus one
  localparam int unsigned DivSteps   = ValueWidth + 1;
  localparam int unsigned WideWidth  = ValueWidth + 1;

  localparam logic [1:0] ModeWrite   = 2'd0;
  localparam logic [1:0] ModeRawPhys = 2'd1;
  localparam logic [1:0] ModePhysRaw = 2'd2;

  localparam logic [1:0] CfgTableSize   = 2'd0;
  localparam logic [1:0] CfgInterpolate = 2'd1;

  // entries picked out by the table search
  typedef struct packed {
    logic                          valid;
    logic                          found;
    logic                          first;
    logic signed [ValueWidth-1:0]  query;
    logic signed [ValueWidth-1:0]  k_lo;
    logic signed [ValueWidth-1:0]  k_hi;
    logic signed [ValueWidth-1:0]  v_lo;
    logic signed [ValueWidth-1:0]  v_hi;
  } sel_t;

  // operands after the slope stage
  typedef struct packed {
    logic                          valid;
    logic                          direct;
    logic                          neg;
    logic signed [ValueWidth-1:0]  base;
    logic [WideWidth-1:0]          mag;
    logic [WideWidth-1:0]          span;
    logic [WideWidth-1:0]          dx;
  } slope_t;

  // one slot of the divider pipeline
  typedef struct packed {
    logic                          valid;
    logic                          direct;
    logic                          neg;
    logic signed [ValueWidth-1:0]  base;
    logic [WideWidth-1:0]          dx;
    logic [WideWidth-1:0]          rem;
    logic [WideWidth-1:0]          num;
    logic [WideWidth-1:0]          quo;
  } div_t;

endpackage

// ===== rtl/core/table_breakpoint_interpolator.sv =====
// channel   | handshake                    | payload
// ----------+------------------------------+-------------------------------------------
// input     | in_valid_i / in_ready_o      | mode, entry_index, entry_raw, entry_phys,
//           |                              | query_value
// result    | out_valid_o / out_ready_i    | result_value
// config    | cfg_we_i (no wait)           | cfg_index_i, cfg_data_i
//
// one item per cycle unless the result register stalls; a query result passes these stages:
// search, slope, multiply, 33 divider steps (one quotient bit each), saturate.
// write items and unused mode codes travel as bubbles and give no result.
// a stalled result register holds the whole pipeline; nothing is dropped.
// reset clears the valid bits and pipeline registers; table entries are not cleared.
// depends on bpi_pkg, bpi_table, bpi_div_step
`timescale 1ns / 1ps

module table_breakpoint_interpolator (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [1:0]                            cfg_index_i,
  input  logic [bpi_pkg::SizeWidth-1:0]         cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            mode_i,
  input  logic [bpi_pkg::IdxWidth-1:0]          entry_index_i,
  input  logic signed [bpi_pkg::ValueWidth-1:0] entry_raw_i,
  input  logic signed [bpi_pkg::ValueWidth-1:0] entry_phys_i,
  input  logic signed [bpi_pkg::ValueWidth-1:0] query_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [bpi_pkg::ValueWidth-1:0] result_value_o
);

  localparam int unsigned VW = bpi_pkg::ValueWidth;
  localparam int unsigned WW = bpi_pkg::WideWidth;
  localparam int unsigned SW = VW + 3;
  localparam logic signed [SW-1:0] SumMax = SW'((64'sd1 <<< (VW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SumMin = -SumMax - SW'(1);

  logic [bpi_pkg::SizeWidth-1:0] table_size_q;
  logic                          interp_q;
  logic                          en;
  logic                          accept;
  bpi_pkg::sel_t                 sel;
  bpi_pkg::slope_t               s1_d, s1_q;
  bpi_pkg::div_t                 s2_d, s2_q;
  bpi_pkg::div_t                 chain [bpi_pkg::DivSteps+1];
  logic signed [WW:0]            dx_full;
  logic signed [WW:0]            dy_full;
  logic [2*WW-1:0]               prod;
  logic signed [SW-1:0]          sum;
  logic signed [SW-1:0]          quo_ext;
  logic signed [VW-1:0]          res_d;
  logic                          out_valid_q;
  logic signed [VW-1:0]          result_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= bpi_pkg::SizeWidth'(1);
      interp_q     <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bpi_pkg::CfgTableSize:   table_size_q <= cfg_data_i;
        bpi_pkg::CfgInterpolate: interp_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  bpi_table u_table (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .accept_i      (accept),
    .mode_i        (mode_i),
    .entry_index_i (entry_index_i),
    .entry_raw_i   (entry_raw_i),
    .entry_phys_i  (entry_phys_i),
    .query_value_i (query_value_i),
    .table_size_i  (table_size_q),
    .sel_o         (sel)
  );

  // slope stage: differences and the cases that need no division
  always_comb begin
    dx_full = (WW+1)'(sel.k_hi) - (WW+1)'(sel.k_lo);
    dy_full = (WW+1)'(sel.v_hi) - (WW+1)'(sel.v_lo);
    s1_d.valid  = sel.valid;
    s1_d.direct = !sel.found || !interp_q || sel.first || (dx_full <= 0);
    s1_d.neg    = dy_full[WW];
    s1_d.base   = sel.v_lo;
    s1_d.mag    = dy_full[WW] ? WW'(-dy_full) : WW'(dy_full);
    s1_d.span   = WW'((WW+1)'(sel.query) - (WW+1)'(sel.k_lo));
    s1_d.dx     = WW'(dx_full);
    if (s1_d.direct) begin
      s1_d.base = (sel.found && interp_q && !sel.first) ? sel.v_lo : sel.v_hi;
      s1_d.neg  = 1'b0;
      s1_d.mag  = '0;
      s1_d.span = '0;
      s1_d.dx   = WW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (en) begin
      s1_q <= s1_d;
    end
  end

  // product stage; the span never exceeds dx, so the top half is below dx
  always_comb begin
    prod        = {{WW{1'b0}}, s1_q.mag} * {{WW{1'b0}}, s1_q.span};
    s2_d.valid  = s1_q.valid;
    s2_d.direct = s1_q.direct;
    s2_d.neg    = s1_q.neg;
    s2_d.base   = s1_q.base;
    s2_d.dx     = s1_q.dx;
    s2_d.rem    = prod[2*WW-1:WW];
    s2_d.num    = prod[WW-1:0];
    s2_d.quo    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else if (en) begin
      s2_q <= s2_d;
    end
  end

  assign chain[0] = s2_q;

  for (genvar k = 0; k < bpi_pkg::DivSteps; k++) begin : g_div
    bpi_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .d_i    (chain[k]),
      .q_o    (chain[k+1])
    );
  end

  // signed sum and saturation
  always_comb begin
    quo_ext = SW'(chain[bpi_pkg::DivSteps].quo);
    sum     = SW'(chain[bpi_pkg::DivSteps].base) +
              (chain[bpi_pkg::DivSteps].neg ? -quo_ext : quo_ext);
    if (sum > SumMax) begin
      res_d = VW'(SumMax);
    end else if (sum < SumMin) begin
      res_d = VW'(SumMin);
    end else begin
      res_d = VW'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      result_q    <= '0;
    end else if (en) begin
      out_valid_q <= chain[bpi_pkg::DivSteps].valid;
      result_q    <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q;

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && mode_i == bpi_pkg::ModeWrite |=> !sel.valid)
    else $error("write item entered the query pipeline");

  a_span_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q.valid && !s1_q.direct |-> s1_q.span != '0 && s1_q.span <= s1_q.dx)
    else $error("interpolation span outside the segment");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[bpi_pkg::DivSteps].valid |-> chain[bpi_pkg::DivSteps].rem <
                                       chain[bpi_pkg::DivSteps].dx)
    else $error("divider remainder not below divisor");

  a_direct_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[bpi_pkg::DivSteps].valid && chain[bpi_pkg::DivSteps].direct
      |-> chain[bpi_pkg::DivSteps].quo == '0)
    else $error("direct lookup carried a quotient");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(s2_q) && $stable(s1_q))
    else $error("pipeline moved during a stall");

endmodule

// ===== rtl/core/bpi_table.sv =====
// breakpoint table storage, write path and parallel search stage
// depends on bpi_pkg
`timescale 1ns / 1ps

module bpi_table (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  accept_i,
  input  logic [1:0]                            mode_i,
  input  logic [bpi_pkg::IdxWidth-1:0]          entry_index_i,
  input  logic signed [bpi_pkg::ValueWidth-1:0] entry_raw_i,
  input  logic signed [bpi_pkg::ValueWidth-1:0] entry_phys_i,
  input  logic signed [bpi_pkg::ValueWidth-1:0] query_value_i,
  input  logic [bpi_pkg::SizeWidth-1:0]         table_size_i,
  output bpi_pkg::sel_t                         sel_o
);

  logic signed [bpi_pkg::ValueWidth-1:0] raw_q  [bpi_pkg::TableDepth];
  logic signed [bpi_pkg::ValueWidth-1:0] phys_q [bpi_pkg::TableDepth];

  logic                                  rev;
  logic [bpi_pkg::SizeWidth-1:0]         n_eff;
  logic [bpi_pkg::TableDepth-1:0]        hit;
  logic                                  found;
  logic [bpi_pkg::IdxWidth-1:0]          idx;
  logic [bpi_pkg::IdxWidth-1:0]          hi_idx;
  logic [bpi_pkg::IdxWidth-1:0]          lo_idx;
  logic [bpi_pkg::SizeWidth-1:0]         last_n;
  bpi_pkg::sel_t                         sel_d, sel_q;

  always_comb begin
    rev = (mode_i == bpi_pkg::ModePhysRaw);
    if (table_size_i == '0) begin
      n_eff = bpi_pkg::SizeWidth'(1);
    end else if (table_size_i > bpi_pkg::SizeWidth'(bpi_pkg::TableDepth)) begin
      n_eff = bpi_pkg::SizeWidth'(bpi_pkg::TableDepth);
    end else begin
      n_eff = table_size_i;
    end
    for (int j = 0; j < bpi_pkg::TableDepth; j++) begin
      hit[j] = (bpi_pkg::SizeWidth'(j) < n_eff) &&
               ((rev ? phys_q[j] : raw_q[j]) >= query_value_i);
    end
    // first key at least the query
    found = 1'b0;
    idx   = '0;
    for (int j = bpi_pkg::TableDepth - 1; j >= 0; j--) begin
      if (hit[j]) begin
        found = 1'b1;
        idx   = bpi_pkg::IdxWidth'(j);
      end
    end
    last_n = n_eff - bpi_pkg::SizeWidth'(1);
    hi_idx = found ? idx : last_n[bpi_pkg::IdxWidth-1:0];
    lo_idx = idx - bpi_pkg::IdxWidth'(1);

    sel_d.valid = accept_i &&
                  (mode_i == bpi_pkg::ModeRawPhys || mode_i == bpi_pkg::ModePhysRaw);
    sel_d.found = found;
    sel_d.first = (idx == '0);
    sel_d.query = query_value_i;
    sel_d.k_hi  = rev ? phys_q[hi_idx] : raw_q[hi_idx];
    sel_d.k_lo  = rev ? phys_q[lo_idx] : raw_q[lo_idx];
    sel_d.v_hi  = rev ? raw_q[hi_idx]  : phys_q[hi_idx];
    sel_d.v_lo  = rev ? raw_q[lo_idx]  : phys_q[lo_idx];
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && mode_i == bpi_pkg::ModeWrite) begin
      raw_q[entry_index_i]  <= entry_raw_i;
      phys_q[entry_index_i] <= entry_phys_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0;
    end else if (en_i) begin
      sel_q <= sel_d;
    end
  end

  assign sel_o = sel_q;

endmodule

// ===== rtl/core/bpi_div_step.sv =====
// one registered restoring division step of the interpolation divider
// depends on bpi_pkg
`timescale 1ns / 1ps

module bpi_div_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  bpi_pkg::div_t d_i,
  output bpi_pkg::div_t q_o
);

  logic [bpi_pkg::WideWidth:0] trial;
  logic [bpi_pkg::WideWidth:0] diff;
  logic                        take;
  bpi_pkg::div_t               step_d, step_q;

  always_comb begin
    trial  = {d_i.rem, d_i.num[bpi_pkg::WideWidth-1]};
    diff   = trial - {1'b0, d_i.dx};
    take   = (trial >= {1'b0, d_i.dx});
    step_d = d_i;
    step_d.rem = take ? diff[bpi_pkg::WideWidth-1:0] : trial[bpi_pkg::WideWidth-1:0];
    step_d.num = {d_i.num[bpi_pkg::WideWidth-2:0], 1'b0};
    step_d.quo = {d_i.quo[bpi_pkg::WideWidth-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (en_i) begin
      step_q <= step_d;
    end
  end

  assign q_o = step_q;

endmodule
